FILE: sv/flou_pkg.sv
// Shared types, constants and coefficient tables of the free-look orientation unit.
`timescale 1ns / 1ps
package flou_pkg;

	localparam int ANGLE_FRAC_BITS  = 8;
	localparam int VECTOR_FRAC_BITS = 15;
	localparam int STEP_SHIFT       = 12 - ANGLE_FRAC_BITS;

	localparam logic [16:0] DEG_FULL    = 17'(360 << ANGLE_FRAC_BITS);
	localparam logic [16:0] DEG_QUARTER = 17'(90 << ANGLE_FRAC_BITS);
	localparam logic [15:0] PITCH_LIM   = 16'(89 << ANGLE_FRAC_BITS);
	localparam logic [16:0] YAW_RESET   = 17'(270 << ANGLE_FRAC_BITS);
	localparam logic [15:0] SENS_RESET  = 16'd410;
	localparam logic [31:0] RAD_PER_DEG_Q32 = 32'd74961321;

	// Yaw step reduction subtracts DEG_FULL << k for k = MOD_STEPS-1 down to 0.
	localparam int MOD_STEPS    = 12;
	localparam int HORNER_TERMS = 5;

	// Datapath operations
	localparam logic [4:0] OP_NOP     = 5'd0;
	localparam logic [4:0] OP_LOAD    = 5'd1;
	localparam logic [4:0] OP_MUL_DX  = 5'd2;
	localparam logic [4:0] OP_STEPX   = 5'd3;
	localparam logic [4:0] OP_MODX    = 5'd4;
	localparam logic [4:0] OP_YAW     = 5'd5;
	localparam logic [4:0] OP_MUL_DY  = 5'd6;
	localparam logic [4:0] OP_PITCH   = 5'd7;
	localparam logic [4:0] OP_ANG     = 5'd8;
	localparam logic [4:0] OP_MUL_X   = 5'd9;
	localparam logic [4:0] OP_SET_X   = 5'd10;
	localparam logic [4:0] OP_MUL_XX  = 5'd11;
	localparam logic [4:0] OP_SET_X2  = 5'd12;
	localparam logic [4:0] OP_MUL_XT  = 5'd13;
	localparam logic [4:0] OP_SET_V   = 5'd14;
	localparam logic [4:0] OP_MUL_VM  = 5'd15;
	localparam logic [4:0] OP_SET_Q   = 5'd16;
	localparam logic [4:0] OP_MUL_QK  = 5'd17;
	localparam logic [4:0] OP_SET_T   = 5'd18;
	localparam logic [4:0] OP_MUL_XTF = 5'd19;
	localparam logic [4:0] OP_SET_S   = 5'd20;
	localparam logic [4:0] OP_MUL_O   = 5'd21;
	localparam logic [4:0] OP_SET_O   = 5'd22;
	localparam logic [4:0] OP_FIN     = 5'd23;

	// Sine slots
	localparam logic [1:0] SIN_YAW   = 2'd0;
	localparam logic [1:0] COS_YAW   = 2'd1;
	localparam logic [1:0] SIN_PITCH = 2'd2;
	localparam logic [1:0] COS_PITCH = 2'd3;

	// Product slots
	localparam logic [1:0] PRD_FRONT_X = 2'd0;
	localparam logic [1:0] PRD_FRONT_Z = 2'd1;
	localparam logic [1:0] PRD_UP_X    = 2'd2;
	localparam logic [1:0] PRD_UP_Z    = 2'd3;

	typedef struct packed {
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
	} flou_in_t;

	typedef struct packed {
		logic signed [15:0] front_x;
		logic signed [15:0] front_y;
		logic signed [15:0] front_z;
		logic signed [15:0] side_x;
		logic signed [15:0] side_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
		logic [16:0]        yaw_out;
		logic signed [15:0] pitch_out;
	} flou_out_t;

	typedef struct packed {
		logic [4:0] op;
		logic [3:0] shift;
		logic [1:0] sine;
		logic [2:0] term;
		logic [1:0] prd;
	} flou_cmd_t;

	typedef struct packed {
		logic out_full;
	} flou_status_t;

	// Horner divisors of the sine series
	function automatic logic [6:0] horner_div(input logic [2:0] term);
		case (term)
			3'd0:    horner_div = 7'd110;
			3'd1:    horner_div = 7'd72;
			3'd2:    horner_div = 7'd42;
			3'd3:    horner_div = 7'd20;
			default: horner_div = 7'd6;
		endcase
	endfunction

	// floor(2^shift / divisor); quotient lands at most one low
	function automatic logic [31:0] horner_recip(input logic [2:0] term);
		case (term)
			3'd0:    horner_recip = 32'd2498890063;
			3'd1:    horner_recip = 32'd3817748707;
			3'd2:    horner_recip = 32'd3272356035;
			3'd3:    horner_recip = 32'd3435973836;
			default: horner_recip = 32'd2863311530;
		endcase
	endfunction

	function automatic logic [5:0] horner_shift(input logic [2:0] term);
		case (term)
			3'd0:    horner_shift = 6'd38;
			3'd1:    horner_shift = 6'd38;
			3'd2:    horner_shift = 6'd37;
			3'd3:    horner_shift = 6'd36;
			default: horner_shift = 6'd34;
		endcase
	endfunction

endpackage

FILE: sv/free_look_orientation_unit.sv
// Top level of the free-look orientation unit: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one beat of mouse deltas
//   (delta_x turns yaw, delta_y turns pitch). Output channel
//   (out_valid/out_ready/out_data) returns one beat per input: the front, side
//   and up basis vectors in Q1.15 plus the updated yaw and pitch.
//   The user writes sensitivity through cfg_wr_en/cfg_wr_data only while idle;
//   the block does not enforce this. It takes effect at the next input beat.
// Sequencing:
//   One beat at a time: a new beat is taken only after the last result is
//   written to the output register. 12 steps reduce the yaw step modulo 360
//   degrees, then each of four sines runs through the single shared 32x32
//   multiplier (scale, square, five Horner terms with reciprocal divide), and
//   four vector products follow on that same multiplier.
// Reset:
//   arst_n clears control, sets yaw to 270 degrees, pitch to zero and
//   sensitivity to its default; the block is ready right after.
// Stall:
//   A finished result holds in the output register. The next beat is already
//   accepted and computed; it then waits before the output register until
//   the receiver takes the previous one.
module free_look_orientation_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  flou_pkg::flou_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output flou_pkg::flou_out_t out_data
);

	flou_pkg::flou_cmd_t    cmd;
	flou_pkg::flou_status_t status;

	// Sequence one update per accepted beat
	flou_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold angles, run the multiplier and drive the output register
	flou_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.out_ready   (out_ready),
		.status      (status),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

FILE: sv/flou_datapath.sv
// Datapath: angle state, shared multiplier, sine evaluation and result register.
`timescale 1ns / 1ps
module flou_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [15:0]            cfg_wr_data,
	input  flou_pkg::flou_in_t     in_data,
	input  flou_pkg::flou_cmd_t    cmd,
	input  logic                   out_ready,
	output flou_pkg::flou_status_t status,
	output logic                   out_valid,
	output flou_pkg::flou_out_t    out_data
);

	function automatic logic [15:0] vec_round(input logic neg, input logic [63:0] mag,
			input int unsigned sh);
		logic [64:0] rounded;
		logic [64:0] lim;
		logic [15:0] v;
		rounded = ({1'b0, mag} + (65'd1 << (sh - 1))) >> sh;
		lim     = 65'((1 << flou_pkg::VECTOR_FRAC_BITS) - 1);
		if (rounded > lim) begin
			v = 16'(lim);
		end else begin
			v = 16'(rounded);
		end
		vec_round = neg ? 16'd0 - v : v;
	endfunction

	localparam int PROD_SH   = 60 - flou_pkg::VECTOR_FRAC_BITS;
	localparam int SINGLE_SH = 30 - flou_pkg::VECTOR_FRAC_BITS;
	localparam logic signed [29:0] PLIM = 30'(flou_pkg::PITCH_LIM);
	localparam logic [17:0] Q1 = 18'(flou_pkg::DEG_QUARTER);
	localparam logic [17:0] Q2 = 18'(2 * flou_pkg::DEG_QUARTER);
	localparam logic [17:0] Q3 = 18'(3 * flou_pkg::DEG_QUARTER);
	localparam logic [30:0] Q30_ONE = 31'(1 << 30);

	logic [15:0]        sens_q;
	logic signed [15:0] dx_q, dy_q;
	logic [16:0]        yaw_q;
	logic signed [15:0] pitch_q;
	logic [27:0]        acc_q;
	logic               neg_q;
	logic [63:0]        prod_q;
	logic [14:0]        r_q;
	logic               rneg_q;
	logic [30:0]        x_q, t_q;
	logic [31:0]        x2_q, v_q, q_q;
	logic [30:0]        sy_q, cy_q, sp_q, cp_q;
	logic               sy_n_q, cy_n_q, sp_n_q, cp_n_q;
	logic [15:0]        fx_q, fz_q, ux_q, uz_q;
	flou_pkg::flou_out_t res_q;
	logic               out_valid_q;

	logic [16:0] dx_mag, dy_mag;
	logic [31:0] mul_a, mul_b;
	logic [27:0] step_m;
	logic [27:0] mod_cand;
	logic [16:0] red;
	logic [17:0] ysum;
	logic signed [29:0] psum;
	logic [16:0] pa;
	logic [17:0] ang, ang_rem, ang_r;
	logic        ang_neg;
	logic [31:0] rem, qf;
	logic [30:0] s_mag;
	logic        prd_neg;
	logic [15:0] prd_val;

	assign dx_mag = dx_q[15] ? 17'd0 - {dx_q[15], dx_q} : {1'b0, dx_q};
	assign dy_mag = dy_q[15] ? 17'd0 - {dy_q[15], dy_q} : {1'b0, dy_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			flou_pkg::OP_MUL_DX: begin
				mul_a = 32'(dx_mag);
				mul_b = 32'(sens_q);
			end
			flou_pkg::OP_MUL_DY: begin
				mul_a = 32'(dy_mag);
				mul_b = 32'(sens_q);
			end
			flou_pkg::OP_MUL_X: begin
				mul_a = 32'(r_q);
				mul_b = flou_pkg::RAD_PER_DEG_Q32;
			end
			flou_pkg::OP_MUL_XX: begin
				mul_a = 32'(x_q);
				mul_b = 32'(x_q);
			end
			flou_pkg::OP_MUL_XT: begin
				mul_a = x2_q;
				mul_b = 32'(t_q);
			end
			flou_pkg::OP_MUL_VM: begin
				mul_a = v_q;
				mul_b = flou_pkg::horner_recip(cmd.term);
			end
			flou_pkg::OP_MUL_QK: begin
				mul_a = q_q;
				mul_b = 32'(flou_pkg::horner_div(cmd.term));
			end
			flou_pkg::OP_MUL_XTF: begin
				mul_a = 32'(x_q);
				mul_b = 32'(t_q);
			end
			flou_pkg::OP_MUL_O: begin
				case (cmd.prd)
					flou_pkg::PRD_FRONT_X: begin
						mul_a = 32'(cy_q);
						mul_b = 32'(cp_q);
					end
					flou_pkg::PRD_FRONT_Z: begin
						mul_a = 32'(sy_q);
						mul_b = 32'(cp_q);
					end
					flou_pkg::PRD_UP_X: begin
						mul_a = 32'(sp_q);
						mul_b = 32'(cy_q);
					end
					default: begin
						mul_a = 32'(sp_q);
						mul_b = 32'(sy_q);
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round the scaled step half away from zero on the magnitude
	assign step_m = 28'((prod_q[31:0] + 32'(1 << (flou_pkg::STEP_SHIFT - 1)))
		>> flou_pkg::STEP_SHIFT);
	assign mod_cand = 28'(flou_pkg::DEG_FULL) << cmd.shift;

	always_comb begin
		red = 17'(acc_q);
		if (neg_q && red != 17'd0) begin
			red = flou_pkg::DEG_FULL - red;
		end
		ysum = 18'(yaw_q) + 18'(red);
		if (ysum >= 18'(flou_pkg::DEG_FULL)) begin
			ysum = ysum - 18'(flou_pkg::DEG_FULL);
		end
	end

	assign psum = 30'(pitch_q) + (dy_q[15] ? 30'sd0 - $signed(30'(step_m))
		: $signed(30'(step_m)));

	// angle reduction to a first-quadrant magnitude
	always_comb begin
		pa = pitch_q[15] ? 17'({pitch_q[15], pitch_q}) + flou_pkg::DEG_FULL
			: 17'(pitch_q);
		ang = (cmd.sine[1] ? 18'(pa) : 18'(yaw_q)) + (cmd.sine[0] ? Q1 : 18'd0);
		if (ang >= 18'(flou_pkg::DEG_FULL)) begin
			ang = ang - 18'(flou_pkg::DEG_FULL);
		end
		if (ang < Q1) begin
			ang_rem = ang;
			ang_r   = ang_rem;
			ang_neg = 1'b0;
		end else if (ang < Q2) begin
			ang_rem = ang - Q1;
			ang_r   = Q1 - ang_rem;
			ang_neg = 1'b0;
		end else if (ang < Q3) begin
			ang_rem = ang - Q2;
			ang_r   = ang_rem;
			ang_neg = 1'b1;
		end else begin
			ang_rem = ang - Q3;
			ang_r   = Q1 - ang_rem;
			ang_neg = 1'b1;
		end
	end

	// correct the reciprocal quotient by one where it came out low
	assign rem   = v_q - prod_q[31:0];
	assign qf    = q_q + ((rem >= 32'(flou_pkg::horner_div(cmd.term))) ? 32'd1 : 32'd0);
	assign s_mag = 31'(prod_q >> 30);

	always_comb begin
		case (cmd.prd)
			flou_pkg::PRD_FRONT_X: prd_neg = cy_n_q ^ cp_n_q;
			flou_pkg::PRD_FRONT_Z: prd_neg = sy_n_q ^ cp_n_q;
			flou_pkg::PRD_UP_X:    prd_neg = ~(sp_n_q ^ cy_n_q);
			default:               prd_neg = ~(sp_n_q ^ sy_n_q);
		endcase
		prd_val = vec_round(prd_neg, prod_q, PROD_SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q      <= flou_pkg::SENS_RESET;
			yaw_q       <= flou_pkg::YAW_RESET;
			pitch_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sens_q <= cfg_wr_data;
			end
			if (cmd.op == flou_pkg::OP_YAW) begin
				yaw_q <= 17'(ysum);
			end
			if (cmd.op == flou_pkg::OP_PITCH) begin
				if (psum > PLIM) begin
					pitch_q <= flou_pkg::PITCH_LIM;
				end else if (psum < -PLIM) begin
					pitch_q <= 16'd0 - flou_pkg::PITCH_LIM;
				end else begin
					pitch_q <= 16'(psum);
				end
			end
			if (cmd.op == flou_pkg::OP_FIN) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (cmd.op)
			flou_pkg::OP_LOAD: begin
				dx_q <= in_data.delta_x;
				dy_q <= in_data.delta_y;
			end
			flou_pkg::OP_STEPX: begin
				acc_q <= step_m;
				neg_q <= dx_q[15];
			end
			flou_pkg::OP_MODX: begin
				if (acc_q >= mod_cand) begin
					acc_q <= acc_q - mod_cand;
				end
			end
			flou_pkg::OP_ANG: begin
				r_q    <= 15'(ang_r);
				rneg_q <= ang_neg;
			end
			flou_pkg::OP_SET_X: begin
				x_q <= 31'(prod_q >> (flou_pkg::ANGLE_FRAC_BITS + 2));
			end
			flou_pkg::OP_SET_X2: begin
				x2_q <= 32'(prod_q >> 30);
				t_q  <= Q30_ONE;
			end
			flou_pkg::OP_SET_V: begin
				v_q <= 32'(prod_q >> 30);
			end
			flou_pkg::OP_SET_Q: begin
				q_q <= 32'(prod_q >> flou_pkg::horner_shift(cmd.term));
			end
			flou_pkg::OP_SET_T: begin
				t_q <= 31'(32'(Q30_ONE) - qf);
			end
			flou_pkg::OP_SET_S: begin
				case (cmd.sine)
					flou_pkg::SIN_YAW: begin
						sy_q   <= s_mag;
						sy_n_q <= rneg_q;
					end
					flou_pkg::COS_YAW: begin
						cy_q   <= s_mag;
						cy_n_q <= rneg_q;
					end
					flou_pkg::SIN_PITCH: begin
						sp_q   <= s_mag;
						sp_n_q <= rneg_q;
					end
					default: begin
						cp_q   <= s_mag;
						cp_n_q <= rneg_q;
					end
				endcase
			end
			flou_pkg::OP_SET_O: begin
				case (cmd.prd)
					flou_pkg::PRD_FRONT_X: fx_q <= prd_val;
					flou_pkg::PRD_FRONT_Z: fz_q <= prd_val;
					flou_pkg::PRD_UP_X:    ux_q <= prd_val;
					default:               uz_q <= prd_val;
				endcase
			end
			flou_pkg::OP_FIN: begin
				res_q.front_x   <= fx_q;
				res_q.front_y   <= vec_round(sp_n_q, 64'(sp_q), SINGLE_SH);
				res_q.front_z   <= fz_q;
				res_q.side_x    <= vec_round(~sy_n_q, 64'(sy_q), SINGLE_SH);
				res_q.side_z    <= vec_round(cy_n_q, 64'(cy_q), SINGLE_SH);
				res_q.up_x      <= ux_q;
				res_q.up_y      <= vec_round(cp_n_q, 64'(cp_q), SINGLE_SH);
				res_q.up_z      <= uz_q;
				res_q.yaw_out   <= yaw_q;
				res_q.pitch_out <= pitch_q;
			end
			default: begin
			end
		endcase
	end

	assign status.out_full = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = res_q;

endmodule

FILE: sv/flou_ctrl.sv
// Controller: sequences the datapath through one update per input beat.
`timescale 1ns / 1ps
module flou_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  flou_pkg::flou_status_t status,
	output flou_pkg::flou_cmd_t    cmd
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_MUL_DX  = 5'd1;
	localparam logic [4:0] S_STEPX   = 5'd2;
	localparam logic [4:0] S_MODX    = 5'd3;
	localparam logic [4:0] S_YAW     = 5'd4;
	localparam logic [4:0] S_MUL_DY  = 5'd5;
	localparam logic [4:0] S_PITCH   = 5'd6;
	localparam logic [4:0] S_ANG     = 5'd7;
	localparam logic [4:0] S_MUL_X   = 5'd8;
	localparam logic [4:0] S_SET_X   = 5'd9;
	localparam logic [4:0] S_MUL_XX  = 5'd10;
	localparam logic [4:0] S_SET_X2  = 5'd11;
	localparam logic [4:0] S_MUL_XT  = 5'd12;
	localparam logic [4:0] S_SET_V   = 5'd13;
	localparam logic [4:0] S_MUL_VM  = 5'd14;
	localparam logic [4:0] S_SET_Q   = 5'd15;
	localparam logic [4:0] S_MUL_QK  = 5'd16;
	localparam logic [4:0] S_SET_T   = 5'd17;
	localparam logic [4:0] S_MUL_XTF = 5'd18;
	localparam logic [4:0] S_SET_S   = 5'd19;
	localparam logic [4:0] S_MUL_O   = 5'd20;
	localparam logic [4:0] S_SET_O   = 5'd21;
	localparam logic [4:0] S_FIN     = 5'd22;

	logic [4:0] state_q, state_d;
	logic [3:0] shift_q, shift_d;
	logic [1:0] sine_q, sine_d;
	logic [2:0] term_q, term_d;
	logic [1:0] prd_q, prd_d;

	always_comb begin
		state_d = state_q;
		shift_d = shift_q;
		sine_d  = sine_q;
		term_d  = term_q;
		prd_d   = prd_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_MUL_DX;
			end
			S_MUL_DX: state_d = S_STEPX;
			S_STEPX: begin
				shift_d = 4'(flou_pkg::MOD_STEPS - 1);
				state_d = S_MODX;
			end
			S_MODX: begin
				if (shift_q == 4'd0) begin
					state_d = S_YAW;
				end else begin
					shift_d = shift_q - 4'd1;
				end
			end
			S_YAW:    state_d = S_MUL_DY;
			S_MUL_DY: state_d = S_PITCH;
			S_PITCH: begin
				sine_d  = flou_pkg::SIN_YAW;
				state_d = S_ANG;
			end
			S_ANG:    state_d = S_MUL_X;
			S_MUL_X:  state_d = S_SET_X;
			S_SET_X:  state_d = S_MUL_XX;
			S_MUL_XX: state_d = S_SET_X2;
			S_SET_X2: begin
				term_d  = 3'd0;
				state_d = S_MUL_XT;
			end
			S_MUL_XT: state_d = S_SET_V;
			S_SET_V:  state_d = S_MUL_VM;
			S_MUL_VM: state_d = S_SET_Q;
			S_SET_Q:  state_d = S_MUL_QK;
			S_MUL_QK: state_d = S_SET_T;
			S_SET_T: begin
				if (term_q == 3'(flou_pkg::HORNER_TERMS - 1)) begin
					state_d = S_MUL_XTF;
				end else begin
					term_d  = term_q + 3'd1;
					state_d = S_MUL_XT;
				end
			end
			S_MUL_XTF: state_d = S_SET_S;
			S_SET_S: begin
				if (sine_q == flou_pkg::COS_PITCH) begin
					prd_d   = flou_pkg::PRD_FRONT_X;
					state_d = S_MUL_O;
				end else begin
					sine_d  = sine_q + 2'd1;
					state_d = S_ANG;
				end
			end
			S_MUL_O: state_d = S_SET_O;
			S_SET_O: begin
				if (prd_q == flou_pkg::PRD_UP_Z) begin
					state_d = S_FIN;
				end else begin
					prd_d   = prd_q + 2'd1;
					state_d = S_MUL_O;
				end
			end
			S_FIN: begin
				if (!status.out_full) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			shift_q <= '0;
			sine_q  <= '0;
			term_q  <= '0;
			prd_q   <= '0;
		end else begin
			state_q <= state_d;
			shift_q <= shift_d;
			sine_q  <= sine_d;
			term_q  <= term_d;
			prd_q   <= prd_d;
		end
	end

	always_comb begin
		cmd.shift = shift_q;
		cmd.sine  = sine_q;
		cmd.term  = term_q;
		cmd.prd   = prd_q;
		case (state_q)
			S_IDLE:    cmd.op = in_valid ? flou_pkg::OP_LOAD : flou_pkg::OP_NOP;
			S_MUL_DX:  cmd.op = flou_pkg::OP_MUL_DX;
			S_STEPX:   cmd.op = flou_pkg::OP_STEPX;
			S_MODX:    cmd.op = flou_pkg::OP_MODX;
			S_YAW:     cmd.op = flou_pkg::OP_YAW;
			S_MUL_DY:  cmd.op = flou_pkg::OP_MUL_DY;
			S_PITCH:   cmd.op = flou_pkg::OP_PITCH;
			S_ANG:     cmd.op = flou_pkg::OP_ANG;
			S_MUL_X:   cmd.op = flou_pkg::OP_MUL_X;
			S_SET_X:   cmd.op = flou_pkg::OP_SET_X;
			S_MUL_XX:  cmd.op = flou_pkg::OP_MUL_XX;
			S_SET_X2:  cmd.op = flou_pkg::OP_SET_X2;
			S_MUL_XT:  cmd.op = flou_pkg::OP_MUL_XT;
			S_SET_V:   cmd.op = flou_pkg::OP_SET_V;
			S_MUL_VM:  cmd.op = flou_pkg::OP_MUL_VM;
			S_SET_Q:   cmd.op = flou_pkg::OP_SET_Q;
			S_MUL_QK:  cmd.op = flou_pkg::OP_MUL_QK;
			S_SET_T:   cmd.op = flou_pkg::OP_SET_T;
			S_MUL_XTF: cmd.op = flou_pkg::OP_MUL_XTF;
			S_SET_S:   cmd.op = flou_pkg::OP_SET_S;
			S_MUL_O:   cmd.op = flou_pkg::OP_MUL_O;
			S_SET_O:   cmd.op = flou_pkg::OP_SET_O;
			S_FIN:     cmd.op = status.out_full ? flou_pkg::OP_NOP : flou_pkg::OP_FIN;
			default:   cmd.op = flou_pkg::OP_NOP;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

FILE: sv/flou_checker.sv
// Port-level checks of the free-look orientation unit, bound to the top level.
`timescale 1ns / 1ps
module flou_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input flou_pkg::flou_out_t out_data
);

	// a result beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat dropped or changed while stalled");

	// one beat in flight: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.yaw_out < flou_pkg::DEG_FULL)
		else $error("yaw out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(out_data.pitch_out) <= $signed(flou_pkg::PITCH_LIM)
			&& $signed(out_data.pitch_out) >= -$signed(flou_pkg::PITCH_LIM))
		else $error("pitch out of range");

endmodule

bind free_look_orientation_unit flou_checker u_flou_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
